### hdl/stdf_pkg.sv
// shared types and constants for the string table deframer
package stdf_pkg;

    localparam int STRINGS_PER_TABLE = 16;

    localparam int BYTE_W  = 8;
    localparam int LEN_W   = 16;
    localparam int ID_W    = 17;
    localparam int POS_W   = 16;
    localparam int CODE_W  = 16;
    localparam int TID_W   = 13;
    localparam int CFG_W   = 16;
    localparam int IDX_W   = 2;
    localparam int TDATA_W = 56;

    localparam logic [IDX_W-1:0] REG_WIDE_MODE    = 2'd0;
    localparam logic [IDX_W-1:0] REG_BLOCK_LENGTH = 2'd1;
    localparam logic [IDX_W-1:0] REG_TABLE_ID     = 2'd2;

    localparam logic KIND_CHAR  = 1'b0;
    localparam logic KIND_TRUNC = 1'b1;

    typedef struct packed {
        logic             wide_mode;
        logic [LEN_W-1:0] block_length;
        logic [TID_W-1:0] table_id;
    } cfg_t;

    typedef struct packed {
        logic              kind;
        logic [ID_W-1:0]   string_id;
        logic [POS_W-1:0]  char_index;
        logic [CODE_W-1:0] char_code;
        logic              last_of_string;
    } res_t;

endpackage

### hdl/stdf_cfg_regs.sv
// configuration registers written through the plain write port
module stdf_cfg_regs (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_wr_en,
    input  logic [stdf_pkg::IDX_W-1:0] cfg_index,
    input  logic [stdf_pkg::CFG_W-1:0] cfg_wdata,
    output stdf_pkg::cfg_t            cfg
);
    import stdf_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_WIDE_MODE:    cfg_next.wide_mode    = cfg_wdata[0];
                REG_BLOCK_LENGTH: cfg_next.block_length = cfg_wdata[LEN_W-1:0];
                REG_TABLE_ID:     cfg_next.table_id     = cfg_wdata[TID_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.wide_mode    <= 1'b1;
            cfg_reg.block_length <= '0;
            cfg_reg.table_id     <= TID_W'(1);
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### hdl/stdf_parser.sv
// parser state and per-byte next-state and result logic
module stdf_parser (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  stdf_pkg::cfg_t              cfg,
    input  logic                        beat_valid,
    input  logic [stdf_pkg::BYTE_W-1:0] beat_byte,
    input  logic                        beat_start,
    output logic                        emit,
    output stdf_pkg::res_t              res
);
    import stdf_pkg::*;

    localparam logic [1:0] PH_LEN_LO = 2'd0;
    localparam logic [1:0] PH_LEN_HI = 2'd1;
    localparam logic [1:0] PH_CHR_LO = 2'd2;
    localparam logic [1:0] PH_CHR_HI = 2'd3;

    logic [1:0]        phase_reg,   phase_next;
    logic [LEN_W-1:0]  bc_reg,      bc_next;
    logic [LEN_W-1:0]  rem_reg,     rem_next;
    logic [ID_W-1:0]   sid_reg,     sid_next;
    logic [POS_W-1:0]  pos_reg,     pos_next;
    logic [BYTE_W-1:0] held_reg,    held_next;
    logic              stopped_reg, stopped_next;

    logic [1:0]        ph;
    logic [LEN_W-1:0]  bc;
    logic [LEN_W-1:0]  rem;
    logic [ID_W-1:0]   sid;
    logic [POS_W-1:0]  pos;
    logic [BYTE_W-1:0] held;
    logic              stp;
    logic [ID_W-1:0]   start_id;
    logic [LEN_W-1:0]  bc_inc;
    logic [LEN_W-1:0]  entry_len;
    logic [LEN_W:0]    entry_bytes;
    logic [LEN_W+1:0]  entry_end;
    logic              entry_over;
    logic [CODE_W-1:0] unit_code;
    logic              unit_last;

    assign start_id = ID_W'(32'(STRINGS_PER_TABLE) * (32'(cfg.table_id) - 32'd1));

    // block start clears the parser state and loads the table's first string id before the byte is parsed
    always_comb begin
        if (beat_start) begin
            ph   = PH_LEN_LO;
            bc   = '0;
            rem  = '0;
            pos  = '0;
            held = '0;
            stp  = 1'b0;
            sid  = start_id;
        end else begin
            ph   = phase_reg;
            bc   = bc_reg;
            rem  = rem_reg;
            pos  = pos_reg;
            held = held_reg;
            stp  = stopped_reg;
            sid  = sid_reg;
        end
    end

    assign bc_inc = bc + LEN_W'(1);

    always_comb begin
        if (ph == PH_LEN_HI) begin
            entry_len   = {beat_byte, held};
            entry_bytes = {entry_len, 1'b0};
        end else begin
            entry_len   = LEN_W'(beat_byte);
            entry_bytes = (LEN_W+1)'(beat_byte);
        end
        entry_end  = (LEN_W+2)'(bc_inc) + (LEN_W+2)'(entry_bytes);
        entry_over = entry_end > (LEN_W+2)'(cfg.block_length);
    end

    assign unit_code = (ph == PH_CHR_HI) ? {beat_byte, held} : CODE_W'(beat_byte);
    assign unit_last = rem <= LEN_W'(1);

    always_comb begin
        phase_next   = ph;
        bc_next      = bc;
        rem_next     = rem;
        sid_next     = sid;
        pos_next     = pos;
        held_next    = held;
        stopped_next = stp;
        emit         = 1'b0;
        res          = '{kind: KIND_TRUNC, string_id: sid, char_index: '0,
                         char_code: '0, last_of_string: 1'b0};
        if (!stp) begin
            unique case (ph)
                PH_LEN_LO, PH_LEN_HI: begin
                    if (ph == PH_LEN_LO && bc >= cfg.block_length) begin
                        // past the end of the block: byte ignored
                        bc_next = bc;
                    end else if (ph == PH_LEN_LO && cfg.wide_mode) begin
                        bc_next   = bc_inc;
                        held_next = beat_byte;
                        if (bc_inc >= cfg.block_length) begin
                            stopped_next = 1'b1;
                            emit         = 1'b1;
                        end else begin
                            phase_next = PH_LEN_HI;
                        end
                    end else begin
                        bc_next = bc_inc;
                        if (entry_over) begin
                            stopped_next = 1'b1;
                            emit         = 1'b1;
                        end else if (entry_len == '0) begin
                            sid_next   = sid + ID_W'(1);
                            phase_next = PH_LEN_LO;
                        end else begin
                            rem_next   = entry_len;
                            pos_next   = '0;
                            phase_next = PH_CHR_LO;
                        end
                    end
                end
                PH_CHR_LO, PH_CHR_HI: begin
                    bc_next = bc_inc;
                    if (ph == PH_CHR_LO && cfg.wide_mode) begin
                        held_next  = beat_byte;
                        phase_next = PH_CHR_HI;
                    end else begin
                        emit = 1'b1;
                        res  = '{kind: KIND_CHAR, string_id: sid, char_index: pos,
                                 char_code: unit_code, last_of_string: unit_last};
                        if (unit_last) begin
                            rem_next   = '0;
                            pos_next   = '0;
                            sid_next   = sid + ID_W'(1);
                            phase_next = PH_LEN_LO;
                        end else begin
                            rem_next   = rem - LEN_W'(1);
                            pos_next   = pos + POS_W'(1);
                            phase_next = PH_CHR_LO;
                        end
                    end
                end
                default: phase_next = ph;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_LEN_LO;
            bc_reg      <= '0;
            rem_reg     <= '0;
            sid_reg     <= '0;
            pos_reg     <= '0;
            held_reg    <= '0;
            stopped_reg <= 1'b0;
        end else if (beat_valid) begin
            phase_reg   <= phase_next;
            bc_reg      <= bc_next;
            rem_reg     <= rem_next;
            sid_reg     <= sid_next;
            pos_reg     <= pos_next;
            held_reg    <= held_next;
            stopped_reg <= stopped_next;
        end
    end

`ifndef SYNTHESIS
    a_stop_holds: assert property (@(posedge aclk)
        aresetn && stopped_reg && !(beat_valid && beat_start) |=> stopped_reg)
        else $error("parser left stopped state without a block start");

    a_trunc_stops: assert property (@(posedge aclk)
        aresetn && beat_valid && emit && res.kind == KIND_TRUNC |=> stopped_reg)
        else $error("truncation beat did not stop the parser");

    a_last_to_len: assert property (@(posedge aclk)
        aresetn && beat_valid && emit && res.kind == KIND_CHAR && res.last_of_string
        |=> phase_reg == PH_LEN_LO && pos_reg == '0)
        else $error("last character did not return to a length prefix");
`endif

endmodule

### hdl/string_table_deframer.sv
// top level: input register, parser, result register and config registers
//
//   channel  dir  handshake          payload
//   s_       in   s_tvalid/s_tready  tdata: data_byte; tuser: block_start
//   m_       out  m_tvalid/m_tready  tdata: string_id, char_index, char_code;
//                                    tuser: kind; tlast: last_of_string
//   cfg_     in   cfg_wr_en          cfg_index, cfg_wdata
//
// one byte per cycle sustained while m_tready is high
// the parser state update between input and result register sets the rate
// aresetn is synchronous: control state and config return to defaults
// a stalled result holds while the input register still takes one more beat
module string_table_deframer (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,   // [7:0] data_byte
    input  logic                           s_tuser,   // [0] block_start
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [stdf_pkg::TDATA_W-1:0]   m_tdata,   // [16:0] string_id,
                                                      // [32:17] char_index,
                                                      // [48:33] char_code
    output logic                           m_tuser,   // [0] kind
    output logic                           m_tlast,
    input  logic                           cfg_wr_en,
    input  logic [stdf_pkg::IDX_W-1:0]     cfg_index,
    input  logic [stdf_pkg::CFG_W-1:0]     cfg_wdata
);
    import stdf_pkg::*;

    cfg_t              cfg;
    logic              in_valid_reg, in_valid_next;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              in_start_reg;
    logic              out_valid_reg, out_valid_next;
    res_t              out_res_reg;
    logic              advance;
    logic              emit;
    res_t              res;

    stdf_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    stdf_parser u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .beat_valid (advance),
        .beat_byte  (in_byte_reg),
        .beat_start (in_start_reg),
        .emit       (emit),
        .res        (res)
    );

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = emit;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg  <= s_tdata;
            in_start_reg <= s_tuser;
        end
        if (advance && emit) begin
            out_res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(TDATA_W - ID_W - POS_W - CODE_W)'(0), out_res_reg.char_code,
                       out_res_reg.char_index, out_res_reg.string_id};
    assign m_tuser  = out_res_reg.kind;
    assign m_tlast  = out_res_reg.last_of_string;

`ifndef SYNTHESIS
    a_in_held: assert property (@(posedge aclk)
        aresetn && in_valid_reg && !advance |=> in_valid_reg)
        else $error("input beat dropped while the result side was stalled");
`endif

endmodule

### dv/tb_string_table_deframer.sv
`timescale 1ns / 100ps
// self-checking testbench for string_table_deframer: byte stream driver, result monitor, predictor
module tb_string_table_deframer;
    import stdf_pkg::*;

    typedef enum logic [1:0] {
        PH_LEN_LO,
        PH_LEN_HI,
        PH_UNIT_LO,
        PH_UNIT_HI
    } parse_phase_t;

    typedef struct {
        logic [BYTE_W-1:0] data;
        logic              start;
    } byte_beat_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata = '0;
    logic                 s_tuser = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [TDATA_W-1:0]   m_tdata;
    logic                 m_tuser;
    logic                 m_tlast;
    logic                 cfg_wr_en = 1'b0;
    logic [IDX_W-1:0]     cfg_index = '0;
    logic [CFG_W-1:0]     cfg_wdata = '0;

    byte_beat_t byte_q[$];
    res_t       pending_results[$];
    int         errors = 0;
    int         beat_count = 0;

    // mirrored registers and parser state
    logic              mdl_wide = 1'b1;
    logic [LEN_W-1:0]  mdl_blen = '0;
    logic [TID_W-1:0]  mdl_tid = 13'd1;
    parse_phase_t      ph = PH_LEN_LO;
    logic [LEN_W-1:0]  consumed = '0;
    logic [LEN_W-1:0]  remaining = '0;
    logic [POS_W-1:0]  pos = '0;
    logic [ID_W-1:0]   sid = '0;
    logic [BYTE_W-1:0] held = '0;
    logic              stopped = 1'b0;

    int burst_left = 0;
    int gap_left = 0;
    int rx_cnt = 0;
    int rx_mode = 0;
    int hold_left = 0;
    int hold_req = 0;
    int hold_served = 0;

    string_table_deframer dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic void push_trunc();
        res_t r;
        r = '0;
        r.kind = KIND_TRUNC;
        r.string_id = sid;
        stopped = 1'b1;
        pending_results.push_back(r);
    endfunction

    function automatic void open_entry(input logic [LEN_W-1:0] len, input int unit_bytes);
        if (int'(consumed) + unit_bytes > int'(mdl_blen)) begin
            push_trunc();
        end else if (len == '0) begin
            sid = sid + 1'b1;
            ph = PH_LEN_LO;
        end else begin
            remaining = len;
            pos = '0;
            ph = PH_UNIT_LO;
        end
    endfunction

    function automatic void emit_unit(input logic [CODE_W-1:0] code);
        res_t r;
        r.kind = KIND_CHAR;
        r.string_id = sid;
        r.char_index = pos;
        r.char_code = code;
        r.last_of_string = (remaining <= 1);
        if (remaining <= 1) begin
            remaining = '0;
            pos = '0;
            sid = sid + 1'b1;
            ph = PH_LEN_LO;
        end else begin
            remaining = remaining - 1'b1;
            pos = pos + 1'b1;
            ph = PH_UNIT_LO;
        end
        pending_results.push_back(r);
    endfunction

    function automatic void deframe_byte(input logic [BYTE_W-1:0] b, input logic start);
        logic [31:0] base;
        if (start) begin
            ph = PH_LEN_LO;
            consumed = '0;
            remaining = '0;
            pos = '0;
            held = '0;
            stopped = 1'b0;
            base = (32'(mdl_tid) - 32'd1) * 32'(STRINGS_PER_TABLE);
            sid = base[ID_W-1:0];
        end
        if (!stopped) begin
            case (ph)
                PH_LEN_LO: begin
                    if (consumed < mdl_blen) begin
                        consumed = consumed + 1'b1;
                        if (mdl_wide) begin
                            held = b;
                            if (consumed >= mdl_blen)
                                push_trunc();
                            else
                                ph = PH_LEN_HI;
                        end else begin
                            open_entry({8'h00, b}, int'(b));
                        end
                    end
                end
                PH_LEN_HI: begin
                    consumed = consumed + 1'b1;
                    open_entry({b, held}, 2 * int'({b, held}));
                end
                PH_UNIT_LO: begin
                    consumed = consumed + 1'b1;
                    if (mdl_wide) begin
                        held = b;
                        ph = PH_UNIT_HI;
                    end else begin
                        emit_unit({8'h00, b});
                    end
                end
                default: begin
                    consumed = consumed + 1'b1;
                    emit_unit({b, held});
                end
            endcase
        end
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $error("%s expected %0h actual %0h", name, want, got);
            errors++;
        end
    endfunction

    function automatic void push_beat(input logic [BYTE_W-1:0] d, input logic st);
        byte_q.push_back('{d, st});
        beat_count++;
    endfunction

    // sender: bursts of random length with random gaps
    always @(posedge aclk) begin
        byte_beat_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                deframe_byte(s_tdata, s_tuser);
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    s_tvalid <= 1'b0;
                end else if (byte_q.size() > 0) begin
                    nxt = byte_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= nxt.data;
                    s_tuser <= nxt.start;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 40);
                        gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end else if (hold_served != hold_req) begin
            hold_left <= 400;
            hold_served <= hold_served + 1;
        end
    end

    // receiver: stall pattern plus result check
    always @(posedge aclk) begin
        res_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (pending_results.size() == 0) begin
                    $error("unexpected beat: kind %0h string_id %0h", m_tuser, m_tdata[16:0]);
                    errors++;
                end else begin
                    want = pending_results.pop_front();
                    check_field("kind", want.kind, m_tuser);
                    check_field("string_id", want.string_id, m_tdata[16:0]);
                    check_field("char_index", want.char_index, m_tdata[32:17]);
                    check_field("char_code", want.char_code, m_tdata[48:33]);
                    check_field("last_of_string", want.last_of_string, m_tlast);
                end
            end
            rx_cnt <= rx_cnt + 1;
            if (rx_cnt % 64 == 0)
                rx_mode <= $urandom_range(0, 3);
            case (rx_mode)
                0: m_tready <= (hold_left == 0);
                1: m_tready <= (hold_left == 0) && ($urandom_range(0, 1) == 1);
                2: m_tready <= (hold_left == 0) && ($urandom_range(0, 3) == 0);
                default: m_tready <= (hold_left == 0) && ((rx_cnt % 8) < 5);
            endcase
        end
    end

    task automatic wait_idle();
        while (!(byte_q.size() == 0 && !s_tvalid && pending_results.size() == 0))
            @(negedge aclk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_WIDE_MODE:    mdl_wide = val[0];
            REG_BLOCK_LENGTH: mdl_blen = val;
            REG_TABLE_ID:     mdl_tid = val[TID_W-1:0];
            default: ;
        endcase
    endtask

    task automatic reconfigure(input logic w, input int blen, input int tid);
        wait_idle();
        repeat (4) @(posedge aclk);
        write_reg(REG_WIDE_MODE, CFG_W'(w));
        write_reg(REG_BLOCK_LENGTH, CFG_W'(blen));
        write_reg(REG_TABLE_ID, CFG_W'(tid));
        @(negedge aclk);
    endtask

    initial begin
        int target, ph_no, blen, tid, budget, cap, len, ub, n, sent, sel;
        logic w, first, broken;
        logic [CODE_W-1:0] code;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // bytes ahead of any block start with zero block length
        push_beat(8'hFF, 1'b0);
        push_beat(8'h00, 1'b0);

        // wide: empty entry, extreme units, length low byte at block end, id wrap
        reconfigure(1'b1, 9, 0);
        push_beat(8'h00, 1'b1);
        push_beat(8'h00, 1'b0);
        push_beat(8'h02, 1'b0);
        push_beat(8'h00, 1'b0);
        push_beat(8'hFF, 1'b0);
        push_beat(8'hFF, 1'b0);
        push_beat(8'h00, 1'b0);
        push_beat(8'h00, 1'b0);
        push_beat(8'h5A, 1'b0);
        push_beat(8'hA5, 1'b0);

        // narrow: units, empty entry, past the end, then body overrun
        reconfigure(1'b0, 5, 4096);
        push_beat(8'h03, 1'b1);
        push_beat(8'h41, 1'b0);
        push_beat(8'h42, 1'b0);
        push_beat(8'h43, 1'b0);
        push_beat(8'h00, 1'b0);
        push_beat(8'h07, 1'b0);
        push_beat(8'h06, 1'b1);

        target = beat_count + 1850;
        ph_no = 0;
        while (beat_count < target) begin
            w = 1'($urandom_range(0, 1));
            case ($urandom_range(0, 9))
                0: blen = 0;
                1: blen = 65535;
                2: blen = $urandom_range(1, 3);
                3: blen = $urandom_range(100, 400);
                default: blen = $urandom_range(4, 60);
            endcase
            case ($urandom_range(0, 5))
                0: tid = 0;
                1: tid = 8191;
                2: tid = 4096;
                3: tid = 1;
                default: tid = $urandom_range(1, 8191);
            endcase
            if (ph_no == 3 || ph_no == 9) begin
                w = 1'b0;
                blen = 200;
            end
            reconfigure(w, blen, tid);
            if (ph_no == 3 || ph_no == 9)
                hold_req++;
            ph_no++;

            // carry on the interrupted block under the new settings
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 6)) push_beat(8'($urandom), 1'b0);

            repeat ($urandom_range(1, 4)) begin
                sel = $urandom_range(0, 9);
                if (sel == 0) begin
                    push_beat(8'($urandom), 1'b1);
                    repeat ($urandom_range(2, 30))
                        push_beat(8'($urandom), $urandom_range(0, 15) == 0);
                end else begin
                    broken = (sel == 1);
                    budget = mdl_blen;
                    cap = $urandom_range(8, 70);
                    sent = 0;
                    first = 1'b1;
                    ub = mdl_wide ? 2 : 1;
                    while (budget > 0 && sent < cap) begin
                        case ($urandom_range(0, 9))
                            0, 1: len = 0;
                            8: len = $urandom_range(5, 20);
                            9: len = mdl_wide ? budget / 2 + $urandom_range(0, 3)
                                 : (budget < 256 ? $urandom_range(budget, 255) : 1);
                            default: len = $urandom_range(1, 4);
                        endcase
                        if (broken)
                            len = mdl_wide ? $urandom_range(0, 65535) : $urandom_range(0, 255);
                        push_beat(8'(len), first);
                        first = 1'b0;
                        budget--;
                        sent++;
                        if (mdl_wide) begin
                            if (budget == 0)
                                break;
                            push_beat(8'(len >> 8), 1'b0);
                            budget--;
                            sent++;
                        end
                        if (len * ub > budget)
                            break;
                        n = (len > 24) ? $urandom_range(0, 24) : len;
                        for (int i = 0; i < n; i++) begin
                            code = CODE_W'($urandom);
                            push_beat(code[7:0], 1'b0);
                            if (mdl_wide)
                                push_beat(code[15:8], 1'b0);
                        end
                        if (n < len)
                            break;
                        budget -= len * ub;
                        sent += len * ub;
                    end
                    push_beat(8'($urandom), first);
                    repeat ($urandom_range(0, 2)) push_beat(8'($urandom), 1'b0);
                end
            end
        end

        wait_idle();
        repeat (10) @(posedge aclk);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #5000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

### string_table_deframer.f
hdl/stdf_pkg.sv
hdl/stdf_cfg_regs.sv
hdl/stdf_parser.sv
hdl/string_table_deframer.sv
dv/tb_string_table_deframer.sv
